// ===== rtl/rorh_pkg.sv =====
// rorh_pkg: shared types and constants for the rate-of-rise heat alarm
// no dependencies; imported by the core and by its checker

package rorh_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NUM_TIERS  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SUPER_LEVEL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_LEVEL = 3'd7;

  // field widths
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned RATE_W = 13;  // smoothed rates stay within +-4095
  localparam int unsigned OUT_W  = 16;

  // reset values of the configuration registers
  localparam logic [CFG_DATA_W-1:0] TIER_RESET        = 32'h7FFF_0258;
  localparam logic signed [TEMP_W-1:0] SUPER_LEVEL_RST = 12'sd2000;
  localparam logic signed [TEMP_W-1:0] CLEAR_LEVEL_RST = 12'sd350;

  localparam logic signed [OUT_W-1:0] DEFAULT_THRESHOLD = 16'sd600;

  // divide by ten: q = (a * DIV10_RECIP) >> DIV10_SHIFT, exact for a < 43690
  localparam int unsigned     DIV10_SHIFT = 18;
  localparam logic [15:0]     DIV10_RECIP = 16'd26215;

  // alarm_state codes
  localparam logic [1:0] ALARM_NONE  = 2'd0;
  localparam logic [1:0] ALARM_HIGH  = 2'd1;
  localparam logic [1:0] ALARM_SUPER = 2'd2;

  typedef struct packed {
    logic [1:0]               alarm_state;
    logic signed [OUT_W-1:0]  threshold_used;
    logic                     deferred;
    logic                     heat_start;
    logic                     super_start;
    logic                     super_end;
    logic                     heat_end;
    logic signed [RATE_W-1:0] rate_short;
    logic signed [RATE_W-1:0] rate_mid;
    logic signed [RATE_W-1:0] rate_long;
  } result_t;

endpackage

// ===== rtl/rate_of_rise_heat_alarm_core.sv =====
// rate_of_rise_heat_alarm_core: rate-of-rise heat alarm, one sample per word
// depends on rorh_pkg

// Takes one signed temperature sample (tenths of a degree) per input word and
// returns one result word per sample. The block sustains one sample per clock
// cycle while out_ready stays high; the sample lands in the input register when
// it is accepted and the result register loads from the single computation
// stage after it, stalled only while a result word waits on out_ready. The first
// sample after reset fills the whole history,
// so its rise is zero. Three smoothed rates over SHORT_LAG, MID_LAG and
// LONG_LAG samples feed six rate tiers (short, short, mid, mid, long, long in
// priority order); the first tier whose rate exceeds its signed limit gives
// the threshold, else 600. While the default threshold is in use, a first
// sample above it is deferred with no alarm decision. Configuration writes
// take effect at once and are meant to happen only while no word is in flight.
module rate_of_rise_heat_alarm_core
  import rorh_pkg::*;
#(
  parameter int unsigned SHORT_LAG = 3,
  parameter int unsigned MID_LAG   = 6,
  parameter int unsigned LONG_LAG  = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [TEMP_W-1:0]     in_sample_temp,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_alarm_state,
  output logic signed [OUT_W-1:0]      out_threshold_used,
  output logic                         out_deferred,
  output logic                         out_heat_start,
  output logic                         out_super_start,
  output logic                         out_super_end,
  output logic                         out_heat_end,
  output logic signed [OUT_W-1:0]      out_rate_short,
  output logic signed [OUT_W-1:0]      out_rate_mid,
  output logic signed [OUT_W-1:0]      out_rate_long,
  // configuration writes
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  // history holds the previous MAX_LAG samples, newest at index 0
  localparam int unsigned MAX_SM  = (SHORT_LAG > MID_LAG) ? SHORT_LAG : MID_LAG;
  localparam int unsigned MAX_LAG = (MAX_SM > LONG_LAG) ? MAX_SM : LONG_LAG;

  typedef enum logic [1:0] {
    MODE_NONE  = ALARM_NONE,
    MODE_HIGH  = ALARM_HIGH,
    MODE_SUPER = ALARM_SUPER
  } mode_t;

  // configuration registers
  logic [CFG_DATA_W-1:0]    tier_r [NUM_TIERS];
  logic signed [TEMP_W-1:0] super_lvl_r;
  logic signed [TEMP_W-1:0] clear_lvl_r;

  // input stage
  logic                     s1_valid_r;
  logic signed [TEMP_W-1:0] s1_temp_r;

  // block state
  logic signed [TEMP_W-1:0] hist_r [MAX_LAG];
  logic                     primed_r;
  logic signed [RATE_W-1:0] sm_short_r, sm_mid_r, sm_long_r;
  logic                     pending_r;
  mode_t                    mode_r;

  // result stage
  logic                     out_valid_r;
  result_t                  res_r;

  // next values
  logic signed [RATE_W-1:0] sm_short_nxt, sm_mid_nxt, sm_long_nxt;
  logic signed [OUT_W-1:0]  thr_nxt;
  logic                     pending_nxt;
  logic                     deferred_nxt;
  mode_t                    mode_nxt;
  logic                     hs_nxt, ss_nxt, se_nxt, he_nxt;

  logic signed [TEMP_W-1:0] lag_short, lag_mid, lag_long;
  logic signed [RATE_W-1:0] tier_rate [NUM_TIERS];
  logic                     advance;
  logic                     fire;

  // smoothed rise: (diff*90 + old*10)/100 == (9*diff + old)/10, toward zero
  function automatic logic signed [RATE_W-1:0] smooth_rate(
    input logic signed [TEMP_W-1:0] cur,
    input logic signed [TEMP_W-1:0] lag,
    input logic signed [RATE_W-1:0] old
  );
    logic signed [RATE_W-1:0] diff;
    logic signed [16:0]       num;
    logic [15:0]              mag;
    logic [31:0]              prod;
    logic [RATE_W-1:0]        quo;
    diff = RATE_W'(cur) - RATE_W'(lag);
    num  = 17'(diff) * 17'sd9 + 17'(old);
    mag  = num[16] ? 16'(-num) : num[15:0];
    prod = 32'(mag) * 32'(DIV10_RECIP);
    quo  = {1'b0, prod[DIV10_SHIFT +: RATE_W-1]};
    return num[16] ? $signed(-quo) : $signed(quo);
  endfunction

  // one-stage pipeline with a result register
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign fire     = s1_valid_r && advance;

  // lagged samples; the very first sample sees itself everywhere
  assign lag_short = primed_r ? hist_r[SHORT_LAG-1] : s1_temp_r;
  assign lag_mid   = primed_r ? hist_r[MID_LAG-1]   : s1_temp_r;
  assign lag_long  = primed_r ? hist_r[LONG_LAG-1]  : s1_temp_r;

  assign sm_short_nxt = smooth_rate(s1_temp_r, lag_short, sm_short_r);
  assign sm_mid_nxt   = smooth_rate(s1_temp_r, lag_mid,   sm_mid_r);
  assign sm_long_nxt  = smooth_rate(s1_temp_r, lag_long,  sm_long_r);

  // tiers pair up on short, mid and long rates
  assign tier_rate[0] = sm_short_nxt;
  assign tier_rate[1] = sm_short_nxt;
  assign tier_rate[2] = sm_mid_nxt;
  assign tier_rate[3] = sm_mid_nxt;
  assign tier_rate[4] = sm_long_nxt;
  assign tier_rate[5] = sm_long_nxt;

  // threshold select: walk from lowest priority so the highest wins
  always_comb begin
    thr_nxt = DEFAULT_THRESHOLD;
    for (int t = NUM_TIERS - 1; t >= 0; t--) begin
      if (OUT_W'(tier_rate[t]) > $signed(tier_r[t][31:16])) begin
        thr_nxt = $signed(tier_r[t][15:0]);
      end
    end
  end

  // deferral and alarm decision
  always_comb begin
    pending_nxt  = 1'b0;
    deferred_nxt = 1'b0;
    mode_nxt     = mode_r;
    hs_nxt       = 1'b0;
    ss_nxt       = 1'b0;
    se_nxt       = 1'b0;
    he_nxt       = 1'b0;

    // above the default threshold: the first such sample only arms the check
    if (thr_nxt == DEFAULT_THRESHOLD && OUT_W'(s1_temp_r) > DEFAULT_THRESHOLD) begin
      pending_nxt  = 1'b1;
      deferred_nxt = !pending_r;
    end

    if (!deferred_nxt) begin
      if (OUT_W'(s1_temp_r) > thr_nxt) begin
        hs_nxt = (mode_r == MODE_NONE);
        if (s1_temp_r >= super_lvl_r) begin
          ss_nxt   = (mode_r != MODE_SUPER);
          mode_nxt = MODE_SUPER;
        end else begin
          se_nxt   = (mode_r == MODE_SUPER);
          mode_nxt = MODE_HIGH;
        end
      end else if (s1_temp_r < clear_lvl_r) begin
        if (mode_r != MODE_NONE) begin
          se_nxt   = (mode_r == MODE_SUPER);
          he_nxt   = 1'b1;
          mode_nxt = MODE_NONE;
        end
      end
    end
  end

  // control, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      primed_r    <= 1'b0;
      sm_short_r  <= '0;
      sm_mid_r    <= '0;
      sm_long_r   <= '0;
      pending_r   <= 1'b0;
      mode_r      <= MODE_NONE;
      for (int t = 0; t < NUM_TIERS; t++) begin
        tier_r[t] <= TIER_RESET;
      end
      super_lvl_r <= SUPER_LEVEL_RST;
      clear_lvl_r <= CLEAR_LEVEL_RST;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        primed_r   <= 1'b1;
        sm_short_r <= sm_short_nxt;
        sm_mid_r   <= sm_mid_nxt;
        sm_long_r  <= sm_long_nxt;
        pending_r  <= pending_nxt;
        mode_r     <= mode_nxt;
        res_r.alarm_state    <= mode_nxt;
        res_r.threshold_used <= thr_nxt;
        res_r.deferred       <= deferred_nxt;
        res_r.heat_start     <= hs_nxt;
        res_r.super_start    <= ss_nxt;
        res_r.super_end      <= se_nxt;
        res_r.heat_end       <= he_nxt;
        res_r.rate_short     <= sm_short_nxt;
        res_r.rate_mid       <= sm_mid_nxt;
        res_r.rate_long      <= sm_long_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SUPER_LEVEL: super_lvl_r <= cfg_wdata[TEMP_W-1:0];
          CFG_CLEAR_LEVEL: clear_lvl_r <= cfg_wdata[TEMP_W-1:0];
          default:         tier_r[cfg_idx] <= cfg_wdata;
        endcase
      end
    end
  end

  // payload registers: input sample and history shift line
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_temp_r <= in_sample_temp;
    end
    if (fire) begin
      hist_r[0] <= s1_temp_r;
      for (int i = 1; i < MAX_LAG; i++) begin
        hist_r[i] <= primed_r ? hist_r[i-1] : s1_temp_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_alarm_state    = res_r.alarm_state;
  assign out_threshold_used = res_r.threshold_used;
  assign out_deferred       = res_r.deferred;
  assign out_heat_start     = res_r.heat_start;
  assign out_super_start    = res_r.super_start;
  assign out_super_end      = res_r.super_end;
  assign out_heat_end       = res_r.heat_end;
  assign out_rate_short     = OUT_W'(res_r.rate_short);
  assign out_rate_mid       = OUT_W'(res_r.rate_mid);
  assign out_rate_long      = OUT_W'(res_r.rate_long);

endmodule

// ===== rtl/rorh_chk.sv =====
// rorh_chk: port-level checks for the rate-of-rise heat alarm core
// depends on rorh_pkg; bound to rate_of_rise_heat_alarm_core below

module rorh_chk
  import rorh_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               out_alarm_state,
  input logic signed [OUT_W-1:0]  out_threshold_used,
  input logic                     out_deferred,
  input logic                     out_heat_start,
  input logic                     out_super_start,
  input logic                     out_super_end,
  input logic                     out_heat_end,
  input logic signed [OUT_W-1:0]  out_rate_short,
  input logic signed [OUT_W-1:0]  out_rate_mid,
  input logic signed [OUT_W-1:0]  out_rate_long
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alarm_state)
      && $stable(out_threshold_used) && $stable(out_deferred)
      && $stable(out_heat_start) && $stable(out_super_start)
      && $stable(out_super_end) && $stable(out_heat_end)
      && $stable(out_rate_short) && $stable(out_rate_mid) && $stable(out_rate_long))
    else $error("result word changed while stalled");

  // a deferred sample raises no event
  a_defer_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deferred |->
      !out_heat_start && !out_super_start && !out_super_end && !out_heat_end)
    else $error("event flag on a deferred sample");

  // start events leave an active alarm, super start leaves super heat
  a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heat_start |-> out_alarm_state != ALARM_NONE)
    else $error("heat start without an active alarm");

  a_super_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_super_start |-> out_alarm_state == ALARM_SUPER)
    else $error("super start outside super heat");

  // heat end always returns to none and excludes a start
  a_end_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heat_end |-> out_alarm_state == ALARM_NONE && !out_heat_start)
    else $error("heat end with alarm still active");

endmodule

bind rate_of_rise_heat_alarm_core rorh_chk u_rorh_chk (.*);

// ===== sim/rorh_checker.sv =====
// rorh_checker: watches the sample and result channels of the heat alarm core,
// predicts every result word and compares it field by field
// depends on rorh_pkg
`timescale 1ns / 100ps

module rorh_checker
  import rorh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [TEMP_W-1:0] in_sample_temp,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [1:0]               out_alarm_state,
  input  logic signed [OUT_W-1:0]  out_threshold_used,
  input  logic                     out_deferred,
  input  logic                     out_heat_start,
  input  logic                     out_super_start,
  input  logic                     out_super_end,
  input  logic                     out_heat_end,
  input  logic signed [OUT_W-1:0]  out_rate_short,
  input  logic signed [OUT_W-1:0]  out_rate_mid,
  input  logic signed [OUT_W-1:0]  out_rate_long,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_idx,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  output int                       n_samples,
  output int                       n_words,
  output int                       n_errors,
  output int                       n_deferred,
  output int                       n_heat_starts,
  output int                       n_super_starts
);

  localparam int SHORT_LAG    = 3;
  localparam int MID_LAG      = 6;
  localparam int LONG_LAG     = 9;
  localparam int HIST_DEPTH   = 10;
  localparam int NEW_WEIGHT   = 90;
  localparam int OLD_WEIGHT   = 10;
  localparam int WEIGHT_SCALE = 100;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [1:0]              alarm_state;
    logic signed [OUT_W-1:0] threshold_used;
    logic                    deferred;
    logic                    heat_start;
    logic                    super_start;
    logic                    super_end;
    logic                    heat_end;
    logic signed [OUT_W-1:0] rate_short;
    logic signed [OUT_W-1:0] rate_mid;
    logic signed [OUT_W-1:0] rate_long;
  } alarm_word_t;

  logic [CFG_DATA_W-1:0]    tier_reg [NUM_TIERS];
  logic signed [TEMP_W-1:0] super_lvl;
  logic signed [TEMP_W-1:0] clear_lvl;

  logic signed [OUT_W-1:0]  history [HIST_DEPTH];
  logic                     primed;
  logic                     confirm_pending;
  logic signed [OUT_W-1:0]  sm_short;
  logic signed [OUT_W-1:0]  sm_mid;
  logic signed [OUT_W-1:0]  sm_long;
  logic [1:0]               heat_mode;

  alarm_word_t              expected_words [$];

  task automatic report_failure(string what);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("[%0t] result word %0d: %s", $time, n_words, what);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_failure($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // int division truncates toward zero
  function automatic logic signed [OUT_W-1:0] smooth_rise(int newest, int lagged, int old);
    int v;
    v = ((newest - lagged) * NEW_WEIGHT + old * OLD_WEIGHT) / WEIGHT_SCALE;
    return OUT_W'(v);
  endfunction

  function automatic alarm_word_t step_alarm(int temp);
    alarm_word_t w;
    int          thr;
    int          rate;
    int          lim;
    logic        fired;
    w = '0;
    if (!primed) begin
      primed = 1'b1;
      for (int i = 0; i < HIST_DEPTH; i++) history[i] = OUT_W'(temp);
    end else begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = OUT_W'(temp);
    end
    sm_short = smooth_rise(history[0], history[SHORT_LAG], sm_short);
    sm_mid   = smooth_rise(history[0], history[MID_LAG], sm_mid);
    sm_long  = smooth_rise(history[0], history[LONG_LAG], sm_long);

    // tiers pair up on short, mid, long rates; first one that fires wins
    thr   = DEFAULT_THRESHOLD;
    fired = 1'b0;
    for (int t = 0; t < NUM_TIERS; t++) begin
      rate = (t < 2) ? sm_short : (t < 4) ? sm_mid : sm_long;
      lim  = $signed(tier_reg[t][31:16]);
      if (!fired && rate > lim) begin
        thr   = $signed(tier_reg[t][15:0]);
        fired = 1'b1;
      end
    end

    if (thr == DEFAULT_THRESHOLD && temp > DEFAULT_THRESHOLD) begin
      if (!confirm_pending) begin
        confirm_pending = 1'b1;
        w.deferred      = 1'b1;
      end
    end else begin
      confirm_pending = 1'b0;
    end

    if (!w.deferred) begin
      if (temp > thr) begin
        if (heat_mode == ALARM_NONE) w.heat_start = 1'b1;
        if (temp >= super_lvl) begin
          if (heat_mode != ALARM_SUPER) begin
            w.super_start = 1'b1;
            heat_mode     = ALARM_SUPER;
          end
        end else begin
          if (heat_mode == ALARM_SUPER) w.super_end = 1'b1;
          heat_mode = ALARM_HIGH;
        end
      end else if (temp < clear_lvl && heat_mode != ALARM_NONE) begin
        if (heat_mode == ALARM_SUPER) w.super_end = 1'b1;
        heat_mode  = ALARM_NONE;
        w.heat_end = 1'b1;
      end
    end

    w.alarm_state    = heat_mode;
    w.threshold_used = OUT_W'(thr);
    w.rate_short     = sm_short;
    w.rate_mid       = sm_mid;
    w.rate_long      = sm_long;
    return w;
  endfunction

  always @(posedge clk) begin
    alarm_word_t want;
    if (!rst_n) begin
      for (int t = 0; t < NUM_TIERS; t++) tier_reg[t] = TIER_RESET;
      super_lvl       = SUPER_LEVEL_RST;
      clear_lvl       = CLEAR_LEVEL_RST;
      primed          = 1'b0;
      confirm_pending = 1'b0;
      sm_short        = '0;
      sm_mid          = '0;
      sm_long         = '0;
      heat_mode       = ALARM_NONE;
      expected_words.delete();
      n_samples       = 0;
      n_words         = 0;
      n_errors        = 0;
      n_deferred      = 0;
      n_heat_starts   = 0;
      n_super_starts  = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_SUPER_LEVEL)      super_lvl = cfg_wdata[TEMP_W-1:0];
        else if (cfg_idx == CFG_CLEAR_LEVEL) clear_lvl = cfg_wdata[TEMP_W-1:0];
        else if (cfg_idx < NUM_TIERS)        tier_reg[cfg_idx] = cfg_wdata;
      end

      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_failure("word with no sample waiting");
        end else begin
          want = expected_words.pop_front();
          check_field("alarm_state", out_alarm_state, want.alarm_state);
          check_field("threshold_used", out_threshold_used, $signed(want.threshold_used));
          check_field("deferred", out_deferred, want.deferred);
          check_field("heat_start", out_heat_start, want.heat_start);
          check_field("super_start", out_super_start, want.super_start);
          check_field("super_end", out_super_end, want.super_end);
          check_field("heat_end", out_heat_end, want.heat_end);
          check_field("rate_short", out_rate_short, $signed(want.rate_short));
          check_field("rate_mid", out_rate_mid, $signed(want.rate_mid));
          check_field("rate_long", out_rate_long, $signed(want.rate_long));
          n_deferred     += want.deferred;
          n_heat_starts  += want.heat_start;
          n_super_starts += want.super_start;
        end
        n_words++;
      end

      if (in_valid && in_ready) begin
        expected_words.push_back(step_alarm(in_sample_temp));
        n_samples++;
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// tb: stimulus and verdict for rate_of_rise_heat_alarm_core
// depends on rorh_pkg, rorh_checker and the core itself
`timescale 1ns / 100ps

module tb;
  import rorh_pkg::*;

  localparam int N_PHASES        = 9;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int TAIL_CYCLES     = 8;    // idle margin after the last result word
  localparam int STALL_LIMIT     = 2000; // cycles with no word moving on either side
  localparam int TEMP_MIN        = -1000;
  localparam int TEMP_MAX        = 2000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [TEMP_W-1:0] in_sample_temp = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_alarm_state;
  logic signed [OUT_W-1:0]  out_threshold_used;
  logic                     out_deferred;
  logic                     out_heat_start;
  logic                     out_super_start;
  logic                     out_super_end;
  logic                     out_heat_end;
  logic signed [OUT_W-1:0]  out_rate_short;
  logic signed [OUT_W-1:0]  out_rate_mid;
  logic signed [OUT_W-1:0]  out_rate_long;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

  int   n_samples, n_words, n_errors, n_deferred, n_heat_starts, n_super_starts;
  logic quiet = 1'b0;   // last phase: no idling on either side
  int   stall_cycles = 0;

  // directed samples at reset settings: priming, jump to the top of the range,
  // deferral, super heat rise and fall, clearing, pending cleared by a dip
  int directed_defaults [13] = '{200, 2000, 2000, 1500, -1000, 650, 500,
                                 700, 700, 2000, 100, -1000, 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rate_of_rise_heat_alarm_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_temp    (in_sample_temp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_alarm_state   (out_alarm_state),
    .out_threshold_used(out_threshold_used),
    .out_deferred      (out_deferred),
    .out_heat_start    (out_heat_start),
    .out_super_start   (out_super_start),
    .out_super_end     (out_super_end),
    .out_heat_end      (out_heat_end),
    .out_rate_short    (out_rate_short),
    .out_rate_mid      (out_rate_mid),
    .out_rate_long     (out_rate_long),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata)
  );

  rorh_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_temp    (in_sample_temp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_alarm_state   (out_alarm_state),
    .out_threshold_used(out_threshold_used),
    .out_deferred      (out_deferred),
    .out_heat_start    (out_heat_start),
    .out_super_start   (out_super_start),
    .out_super_end     (out_super_end),
    .out_heat_end      (out_heat_end),
    .out_rate_short    (out_rate_short),
    .out_rate_mid      (out_rate_mid),
    .out_rate_long     (out_rate_long),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .n_samples         (n_samples),
    .n_words           (n_words),
    .n_errors          (n_errors),
    .n_deferred        (n_deferred),
    .n_heat_starts     (n_heat_starts),
    .n_super_starts    (n_super_starts)
  );

  // watchdog: any word moving on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("** rate_of_rise_heat_alarm_core: FAILED **");
        $finish;
      end
    end
  end

  // result side: runs of ready broken by stall bursts
  initial begin
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
    end
  end

  function automatic int clamp_temp(int t);
    if (t > TEMP_MAX) return TEMP_MAX;
    if (t < TEMP_MIN) return TEMP_MIN;
    return t;
  endfunction

  // tier word: signed rate limit on top, signed threshold below
  function automatic logic [CFG_DATA_W-1:0] rand_tier();
    logic signed [15:0] lim;
    logic signed [15:0] thr;
    lim = 16'(int'($urandom_range(0, 460)) - 60);
    thr = ($urandom_range(0, 3) == 0) ? DEFAULT_THRESHOLD : 16'($urandom_range(200, 1600));
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: lim = 16'sh7FFF;
      2: lim = 16'sh8000;
      3: thr = 16'sh8000;
      4: thr = 16'sh7FFF;
      default: ;
    endcase
    return {lim, thr};
  endfunction

  // one sample word; valid stays up across back-to-back words
  task automatic send_sample(int t);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_temp <= TEMP_W'(t);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the sender until every result word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (n_words != n_samples) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // phase 0 restores reset values, 1 pins the threshold at the top,
  // 2 pins it at the bottom with every alarm super, 3 makes alarms stick
  task automatic configure(int phase);
    logic [CFG_DATA_W-1:0] tier_val;
    int super_lvl;
    int clear_lvl;
    int i;
    super_lvl = int'($urandom_range(0, 3000)) + TEMP_MIN;
    clear_lvl = int'($urandom_range(0, 1200)) - 200;
    for (i = 0; i < NUM_TIERS; i++) begin
      case (phase)
        0:       tier_val = TIER_RESET;
        1:       tier_val = (i == 0) ? {16'sh8000, 16'sh7FFF} : rand_tier();
        2:       tier_val = (i == 0) ? {16'sh8000, 16'sh8000} : rand_tier();
        default: tier_val = rand_tier();
      endcase
      write_reg(CFG_IDX_W'(i), tier_val);
    end
    case (phase)
      0: begin
        super_lvl = SUPER_LEVEL_RST;
        clear_lvl = CLEAR_LEVEL_RST;
      end
      2: begin
        super_lvl = TEMP_MIN;
        clear_lvl = TEMP_MAX;
      end
      3: begin
        super_lvl = TEMP_MAX;
        clear_lvl = TEMP_MIN;
      end
      default: ;
    endcase
    write_reg(CFG_SUPER_LEVEL, CFG_DATA_W'(super_lvl));
    write_reg(CFG_CLEAR_LEVEL, CFG_DATA_W'(clear_lvl));
  endtask

  initial begin
    int t;
    int n;
    int kind;
    int seg_len;
    int level;
    int k;
    int phase;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset settings
    foreach (directed_defaults[j]) send_sample(directed_defaults[j]);
    drain();

    // a tier that fires with threshold 600 still defers
    write_reg(CFG_IDX_W'(0), {16'sh8000, DEFAULT_THRESHOLD});
    send_sample(700);
    send_sample(700);
    send_sample(300);
    drain();

    // lowest threshold: every sample alarms, all of them super heat
    write_reg(CFG_IDX_W'(0), {16'sh8000, 16'sh8000});
    write_reg(CFG_SUPER_LEVEL, CFG_DATA_W'(TEMP_MIN));
    write_reg(CFG_CLEAR_LEVEL, CFG_DATA_W'(TEMP_MAX));
    send_sample(TEMP_MIN);
    send_sample(TEMP_MAX);
    send_sample(TEMP_MIN);
    drain();

    // random part: ramps push the rates through the tiers, hovering near 600
    // or the clear level works the deferral and clearing, noise and extremes
    // fill the rest
    t = 200;
    for (phase = 0; phase < N_PHASES; phase++) begin
      configure(phase);
      quiet <= (phase == N_PHASES - 1);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        kind    = $urandom_range(0, 5);
        seg_len = $urandom_range(4, 24);
        level   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(250, 450))
                                              : int'($urandom_range(550, 700));
        for (k = 0; k < seg_len && n < ITEMS_PER_PHASE; k++) begin
          case (kind)
            0, 1:    t = clamp_temp(t + int'($urandom_range(0, 160)));
            2:       t = clamp_temp(t - int'($urandom_range(0, 160)));
            3:       t = level + int'($urandom_range(0, 80)) - 40;
            4:       t = int'($urandom_range(0, 3000)) + TEMP_MIN;
            default: t = ($urandom_range(0, 1) == 0) ? TEMP_MAX : TEMP_MIN;
          endcase
          send_sample(t);
          n++;
        end
      end
      drain();
    end

    $display("%0d samples over %0d settings phases, %0d result words checked",
             n_samples, N_PHASES, n_words);
    $display("%0d deferrals, %0d heat alarms started, %0d super heat entries, %0d errors",
             n_deferred, n_heat_starts, n_super_starts, n_errors);
    if (n_errors == 0)
      $display("** rate_of_rise_heat_alarm_core: PASSED **");
    else
      $display("** rate_of_rise_heat_alarm_core: FAILED **");
    $finish;
  end

endmodule
